FILE: sv/mask_bounding_box_assert.svh
// Assertion macros for the checker file of the mask bounding box.
`ifndef MASK_BOUNDING_BOX_ASSERT_SVH
`define MASK_BOUNDING_BOX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBB_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mask_bounding_box check failed");

// The consequent must hold in the cycle after the antecedent.
`define MBB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mask_bounding_box check failed");

`endif

FILE: sv/mbb_pkg.sv
// Package with the widths, register indexes and helpers of the mask bounding box.
`default_nettype none

package mbb_pkg;

  localparam int DIM_W   = 13;
  localparam int COORD_W = 12;
  localparam int COL_W   = 9;
  localparam int ROW_W   = 12;
  localparam int RBYTE_W = 10;

  localparam logic [DIM_W-1:0] MAX_DIMENSION = 13'd4096;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // Zero counts as one, anything above the maximum counts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    begin
      if (v == '0) begin
        r = 13'd1;
      end else if (v > MAX_DIMENSION) begin
        r = MAX_DIMENSION;
      end else begin
        r = v;
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

FILE: sv/mask_bounding_box.sv
// Top level of the mask bounding box: byte counters, bound tracking and result register.
// Mask bytes enter on mask_valid/mask_stall, one request per byte, row after row,
// ceil(image_width/8) bytes per row with bit b of a byte holding pixel 8k+b.
// After the last byte of the last row one rectangle request leaves on
// rect_valid/rect_stall: found plus the exclusive bounds, or found=0 and zeros.
// Bytes that do not close a frame produce no result request.
// image_width and image_height are set through cfg_write/cfg_index/cfg_data; the user
// writes them only while no frame is in flight, which the block does not enforce;
// zero counts as one and values above 4096 clamp.
// The accepted last byte passes the input register, then the bound update that loads
// the result register. The bound update takes one byte per cycle but for one case:
// while a result waits under rect_stall, bytes keep flowing until the next
// frame-closing byte reaches the update stage; it and the input side then hold.
// Reset (rst, synchronous) sets both dimensions to 1, clears the counters and upper
// bounds, sets the lower bounds to 1, and empties the input and result registers.
`default_nettype none

module mask_bounding_box (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        mask_valid,
  output      logic                        mask_stall,
  input  wire logic [7:0]                  mask_byte,
  output      logic                        rect_valid,
  input  wire logic                        rect_stall,
  output      logic                        found,
  output      logic [mbb_pkg::COORD_W-1:0] rect_left,
  output      logic [mbb_pkg::COORD_W-1:0] rect_top,
  output      logic [mbb_pkg::DIM_W-1:0]   rect_right,
  output      logic [mbb_pkg::DIM_W-1:0]   rect_bottom,
  input  wire logic                        cfg_write,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [mbb_pkg::DIM_W-1:0]   cfg_data
);

  logic [mbb_pkg::DIM_W-1:0]   image_width;
  logic [mbb_pkg::DIM_W-1:0]   image_height;

  logic                        s1_valid;
  logic [7:0]                  s1_byte;

  logic [mbb_pkg::COL_W-1:0]   byte_column;
  logic [mbb_pkg::ROW_W-1:0]   row_index;
  logic [mbb_pkg::DIM_W-1:0]   min_x;
  logic [mbb_pkg::COORD_W-1:0] max_x;
  logic [mbb_pkg::DIM_W-1:0]   min_y;
  logic [mbb_pkg::COORD_W-1:0] max_y;
  logic                        any_seen;

  logic [mbb_pkg::DIM_W-1:0]   min_x_next;
  logic [mbb_pkg::COORD_W-1:0] max_x_next;
  logic [mbb_pkg::DIM_W-1:0]   min_y_next;
  logic [mbb_pkg::COORD_W-1:0] max_y_next;

  logic [mbb_pkg::DIM_W-1:0]   w_eff;
  logic [mbb_pkg::DIM_W-1:0]   h_eff;
  logic [mbb_pkg::COORD_W-1:0] x0;
  logic [mbb_pkg::DIM_W-1:0]   x0_ext;
  logic [mbb_pkg::DIM_W-1:0]   remaining;
  logic [7:0]                  bits;
  logic [2:0]                  lo;
  logic [2:0]                  hi;
  logic [mbb_pkg::COORD_W-1:0] x_lo;
  logic [mbb_pkg::COORD_W-1:0] x_hi;
  logic [mbb_pkg::DIM_W-1:0]   row_sum;
  logic [mbb_pkg::RBYTE_W-1:0] row_bytes;
  logic [mbb_pkg::RBYTE_W-1:0] col_plus;
  logic [mbb_pkg::DIM_W-1:0]   row_plus;
  logic                        last_col;
  logic                        last_row;
  logic                        s1_end;
  logic                        proceed;
  logic                        in_accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd1;
      image_height <= 13'd1;
    end else if (cfg_write) begin
      case (mbb_pkg::cfg_reg_t'(cfg_index))
        mbb_pkg::REG_WIDTH:  image_width  <= cfg_data;
        mbb_pkg::REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = mbb_pkg::clamp_dim(image_width);
  assign h_eff = mbb_pkg::clamp_dim(image_height);

  // Pixel position of the byte and masking of bits past the right edge.
  assign x0        = {byte_column, 3'b000};
  assign x0_ext    = {1'b0, x0};
  assign remaining = w_eff - x0_ext;

  always_comb begin
    if (x0_ext >= w_eff) begin
      bits = 8'h00;
    end else if (remaining < 13'd8) begin
      bits = s1_byte & ~(8'hFF << remaining[2:0]);
    end else begin
      bits = s1_byte;
    end
  end

  always_comb begin
    lo = 3'd0;
    hi = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (bits[i]) begin
        lo = 3'(i);
      end
    end
    for (int i = 0; i < 8; i++) begin
      if (bits[i]) begin
        hi = 3'(i);
      end
    end
  end

  assign x_lo = x0 + {9'd0, lo};
  assign x_hi = x0 + {9'd0, hi};

  // The first visible pixel of a frame loads the bounds outright.
  always_comb begin
    min_x_next = min_x;
    max_x_next = max_x;
    min_y_next = min_y;
    max_y_next = max_y;
    if (bits != 8'h00) begin
      if (!any_seen) begin
        min_x_next = {1'b0, x_lo};
        max_x_next = x_hi;
        min_y_next = {1'b0, row_index};
        max_y_next = row_index;
      end else begin
        if ({1'b0, x_lo} < min_x) begin
          min_x_next = {1'b0, x_lo};
        end
        if (x_hi > max_x) begin
          max_x_next = x_hi;
        end
        if ({1'b0, row_index} < min_y) begin
          min_y_next = {1'b0, row_index};
        end
        if (row_index > max_y) begin
          max_y_next = row_index;
        end
      end
    end
  end

  assign row_sum   = w_eff + 13'd7;
  assign row_bytes = row_sum[mbb_pkg::DIM_W-1:3];
  assign col_plus  = {1'b0, byte_column} + 10'd1;
  assign row_plus  = {1'b0, row_index} + 13'd1;
  assign last_col  = (col_plus >= row_bytes);
  assign last_row  = (row_plus >= h_eff);
  assign s1_end    = last_col && last_row;

  // A frame-closing byte waits only while the previous result is held.
  assign proceed    = s1_valid && (!s1_end || !rect_valid || !rect_stall);
  assign mask_stall = s1_valid && !proceed;
  assign in_accept  = mask_valid && !mask_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (proceed) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= mask_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column <= '0;
      row_index   <= '0;
      min_x       <= 13'd1;
      max_x       <= '0;
      min_y       <= 13'd1;
      max_y       <= '0;
      any_seen    <= 1'b0;
    end else if (proceed) begin
      if (s1_end) begin
        byte_column <= '0;
        row_index   <= '0;
        min_x       <= w_eff;
        max_x       <= '0;
        min_y       <= h_eff;
        max_y       <= '0;
        any_seen    <= 1'b0;
      end else begin
        min_x    <= min_x_next;
        max_x    <= max_x_next;
        min_y    <= min_y_next;
        max_y    <= max_y_next;
        any_seen <= any_seen || (bits != 8'h00);
        if (last_col) begin
          byte_column <= '0;
          row_index   <= row_plus[mbb_pkg::ROW_W-1:0];
        end else begin
          byte_column <= col_plus[mbb_pkg::COL_W-1:0];
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_valid <= 1'b0;
    end else if (proceed && s1_end) begin
      rect_valid <= 1'b1;
    end else if (!rect_stall) begin
      rect_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && s1_end) begin
      if (any_seen || (bits != 8'h00)) begin
        found       <= 1'b1;
        rect_left   <= min_x_next[mbb_pkg::COORD_W-1:0];
        rect_top    <= min_y_next[mbb_pkg::COORD_W-1:0];
        rect_right  <= {1'b0, max_x_next} + 13'd1;
        rect_bottom <= {1'b0, max_y_next} + 13'd1;
      end else begin
        found       <= 1'b0;
        rect_left   <= '0;
        rect_top    <= '0;
        rect_right  <= '0;
        rect_bottom <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/mbb_checker.sv
// Port-level checker for the mask bounding box and its bind to the top level.
`default_nettype none

`include "mask_bounding_box_assert.svh"

module mbb_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        mask_stall,
  input wire logic                        rect_valid,
  input wire logic                        rect_stall,
  input wire logic                        found,
  input wire logic [mbb_pkg::COORD_W-1:0] rect_left,
  input wire logic [mbb_pkg::COORD_W-1:0] rect_top,
  input wire logic [mbb_pkg::DIM_W-1:0]   rect_right,
  input wire logic [mbb_pkg::DIM_W-1:0]   rect_bottom
);

  logic [2*mbb_pkg::COORD_W+2*mbb_pkg::DIM_W:0] rect_bus;
  logic                                         rect_ok;

  assign rect_bus = {found, rect_left, rect_top, rect_right, rect_bottom};
  assign rect_ok  = ({1'b0, rect_left} < rect_right) && ({1'b0, rect_top} < rect_bottom);

  // A held result must stay valid and unchanged.
  `MBB_ASSERT_NEXT(a_result_held, rect_valid && rect_stall, rect_valid)
  `MBB_ASSERT_NEXT(a_result_stable, rect_valid && rect_stall, $stable(rect_bus))

  // The input side only backs up behind a result that is itself held.
  `MBB_ASSERT_NOW(a_stall_cause, mask_stall, rect_valid && rect_stall)

  // A found rectangle is never empty.
  `MBB_ASSERT_NOW(a_rect_nonempty, rect_valid && found, rect_ok)

endmodule

bind mask_bounding_box mbb_checker u_mbb_checker (.*);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for mask_bounding_box with directed and random masks and flow control.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_BYTES  = 800;
  localparam int TALL_ROWS     = 256;
  localparam int MAX_REPORTS   = 10;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic                        found;
    logic [mbb_pkg::COORD_W-1:0] left;
    logic [mbb_pkg::COORD_W-1:0] top;
    logic [mbb_pkg::DIM_W-1:0]   right;
    logic [mbb_pkg::DIM_W-1:0]   bottom;
  } rect_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  // Tracks the bounding box of the mask bytes taken in and holds the rectangles still owed.
  class bbox_checker;
    logic [mbb_pkg::DIM_W-1:0]   width_reg;
    logic [mbb_pkg::DIM_W-1:0]   height_reg;
    logic [mbb_pkg::COL_W-1:0]   byte_col;
    logic [mbb_pkg::ROW_W-1:0]   row_idx;
    logic [mbb_pkg::DIM_W-1:0]   min_x;
    logic [mbb_pkg::DIM_W-1:0]   min_y;
    logic [mbb_pkg::COORD_W-1:0] max_x;
    logic [mbb_pkg::COORD_W-1:0] max_y;
    logic                        any_seen;
    rect_t                       expected_rects[$];
    int                          bytes_seen;
    int                          rects_checked;
    int                          rects_found;
    int                          errors;

    function new();
      width_reg     = 13'd1;
      height_reg    = 13'd1;
      bytes_seen    = 0;
      rects_checked = 0;
      rects_found   = 0;
      errors        = 0;
      start_frame();
    endfunction

    static function int effective_dim(logic [mbb_pkg::DIM_W-1:0] v);
      if (v == '0) begin
        return 1;
      end else if (v > mbb_pkg::MAX_DIMENSION) begin
        return int'(mbb_pkg::MAX_DIMENSION);
      end
      return int'(v);
    endfunction

    function void start_frame();
      byte_col = '0;
      row_idx  = '0;
      min_x    = mbb_pkg::DIM_W'(effective_dim(width_reg));
      min_y    = mbb_pkg::DIM_W'(effective_dim(height_reg));
      max_x    = '0;
      max_y    = '0;
      any_seen = 1'b0;
    endfunction

    function void write_reg(mbb_pkg::cfg_reg_t idx, logic [mbb_pkg::DIM_W-1:0] value);
      case (idx)
        mbb_pkg::REG_WIDTH:  width_reg = value;
        mbb_pkg::REG_HEIGHT: height_reg = value;
        default:    ;
      endcase
    endfunction

    function void track_byte(logic [7:0] data);
      int         w;
      int         h;
      int         row_bytes;
      int         x0;
      int         lo;
      int         hi;
      logic [7:0] bits;
      rect_t      rect;
      w         = effective_dim(width_reg);
      h         = effective_dim(height_reg);
      row_bytes = (w + 7) / 8;
      x0        = int'(byte_col) * 8;
      bytes_seen++;

      // Pixels at or past the width never count, even when the width shrank mid-frame.
      if (x0 >= w) begin
        bits = '0;
      end else if (w - x0 < 8) begin
        bits = data & 8'((1 << (w - x0)) - 1);
      end else begin
        bits = data;
      end

      if (bits != '0) begin
        lo = 0;
        hi = 7;
        while (!bits[lo]) lo++;
        while (!bits[hi]) hi--;
        if (!any_seen) begin
          min_x    = mbb_pkg::DIM_W'(x0 + lo);
          max_x    = mbb_pkg::COORD_W'(x0 + hi);
          min_y    = mbb_pkg::DIM_W'(row_idx);
          max_y    = row_idx;
          any_seen = 1'b1;
        end else begin
          if (x0 + lo < int'(min_x)) begin
            min_x = mbb_pkg::DIM_W'(x0 + lo);
          end
          if (x0 + hi > int'(max_x)) begin
            max_x = mbb_pkg::COORD_W'(x0 + hi);
          end
          if (row_idx < min_y) begin
            min_y = mbb_pkg::DIM_W'(row_idx);
          end
          if (row_idx > max_y) begin
            max_y = row_idx;
          end
        end
      end

      if (int'(byte_col) + 1 < row_bytes) begin
        byte_col = byte_col + 1'b1;
        return;
      end
      byte_col = '0;
      if (int'(row_idx) + 1 < h) begin
        row_idx = row_idx + 1'b1;
        return;
      end

      if (any_seen) begin
        rect.found  = 1'b1;
        rect.left   = min_x[mbb_pkg::COORD_W-1:0];
        rect.top    = min_y[mbb_pkg::COORD_W-1:0];
        rect.right  = {1'b0, max_x} + 1'b1;
        rect.bottom = {1'b0, max_y} + 1'b1;
        rects_found++;
      end else begin
        rect = '0;
      end
      expected_rects.insert(expected_rects.size(), rect);
      start_frame();
    endfunction

    function void report(string field, logic [mbb_pkg::DIM_W-1:0] want,
                         logic [mbb_pkg::DIM_W-1:0] got);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("mismatch on %s of rectangle %0d: expected %0d, got %0d",
                 field, rects_checked, want, got);
      end
    endfunction

    function void check_rect(rect_t got);
      rect_t want;
      if (expected_rects.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("rectangle request with no frame closed: found=%0d left=%0d top=%0d",
                   got.found, got.left, got.top);
        end
        return;
      end
      want = expected_rects[0];
      expected_rects.delete(0);
      rects_checked++;
      if (got.found !== want.found) begin
        report("found", mbb_pkg::DIM_W'(want.found), mbb_pkg::DIM_W'(got.found));
      end
      if (got.left !== want.left) begin
        report("rect_left", mbb_pkg::DIM_W'(want.left), mbb_pkg::DIM_W'(got.left));
      end
      if (got.top !== want.top) begin
        report("rect_top", mbb_pkg::DIM_W'(want.top), mbb_pkg::DIM_W'(got.top));
      end
      if (got.right !== want.right) begin
        report("rect_right", want.right, got.right);
      end
      if (got.bottom !== want.bottom) begin
        report("rect_bottom", want.bottom, got.bottom);
      end
    endfunction
  endclass

  logic                        clk         = 1'b0;
  logic                        rst         = 1'b1;
  logic                        mask_valid  = 1'b0;
  logic                        mask_stall;
  logic [7:0]                  mask_byte   = '0;
  logic                        rect_valid;
  logic                        rect_stall  = 1'b0;
  logic                        found;
  logic [mbb_pkg::COORD_W-1:0] rect_left;
  logic [mbb_pkg::COORD_W-1:0] rect_top;
  logic [mbb_pkg::DIM_W-1:0]   rect_right;
  logic [mbb_pkg::DIM_W-1:0]   rect_bottom;
  logic                        cfg_write   = 1'b0;
  logic [0:0]                  cfg_index   = '0;
  logic [mbb_pkg::DIM_W-1:0]   cfg_data    = '0;

  bbox_checker bbox;
  int          hold_requests = 0;
  int          burst_left    = 0;
  bit          no_gaps       = 1'b0;
  int unsigned cycle_count   = 0;

  mask_bounding_box u_dut (
    .clk         (clk),
    .rst         (rst),
    .mask_valid  (mask_valid),
    .mask_stall  (mask_stall),
    .mask_byte   (mask_byte),
    .rect_valid  (rect_valid),
    .rect_stall  (rect_stall),
    .found       (found),
    .rect_left   (rect_left),
    .rect_top    (rect_top),
    .rect_right  (rect_right),
    .rect_bottom (rect_bottom),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Both handshakes are judged on the values present just before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (mask_valid && !mask_stall) begin
        bbox.track_byte(mask_byte);
      end
      if (rect_valid && !rect_stall) begin
        bbox.check_rect(rect_t'{found, rect_left, rect_top, rect_right, rect_bottom});
      end
    end
  end

  initial begin : receiver
    stall_mode_t mode;
    int          mode_left;
    int          hold_left;
    int          holds_served;
    mode         = STALL_NONE;
    mode_left    = 0;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rect_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  rect_stall <= 1'b0;
          STALL_LIGHT: rect_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: rect_stall <= ($urandom_range(0, 3) != 0);
          default:     rect_stall <= !rect_stall;
        endcase
      end
    end
  end

  function automatic logic [7:0] random_pixels(int fill_pct);
    if ($urandom_range(0, 99) < fill_pct) begin
      return 8'($urandom_range(1, 255));
    end
    return 8'h00;
  endfunction

  task automatic send_byte(input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        mask_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    mask_valid <= 1'b1;
    mask_byte  <= data;
    do @(posedge clk); while (mask_stall);
  endtask

  // Waits for every owed rectangle, then lets bytes that close no frame drain from the pipe.
  task automatic idle_wait();
    mask_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (bbox.expected_rects.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(input logic [mbb_pkg::DIM_W-1:0] w,
                          input logic [mbb_pkg::DIM_W-1:0] h);
    idle_wait();
    cfg_write <= 1'b1;
    cfg_index <= mbb_pkg::REG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    bbox.write_reg(mbb_pkg::REG_WIDTH, w);
    cfg_index <= mbb_pkg::REG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    bbox.write_reg(mbb_pkg::REG_HEIGHT, h);
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    int                        total;
    int                        frames;
    int                        fill_pct;
    int                        random_bytes;
    int                        first_row;
    logic [mbb_pkg::DIM_W-1:0] w;
    logic [mbb_pkg::DIM_W-1:0] h;
    bbox = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // At the reset size of one by one, every byte is a frame and only bit 0 counts.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFE);
    set_dims(13'd0, 13'd0);
    send_byte(8'h01);
    // Twelve pixels wide: the upper half of each second byte lies outside the mask.
    set_dims(13'd12, 13'd2);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h18);
    set_dims(13'd16, 13'd3);
    repeat (6) send_byte(8'hFF);
    // Height cut below the current row: the next row end closes the frame.
    set_dims(13'd8, 13'd4);
    send_byte(8'h00);
    send_byte(8'h10);
    set_dims(13'd8, 13'd1);
    send_byte(8'h01);
    // Width cut mid-row: the remaining byte lies wholly past the width.
    set_dims(13'd24, 13'd1);
    send_byte(8'h01);
    send_byte(8'h02);
    set_dims(13'd8, 13'd1);
    send_byte(8'hFF);

    // One-byte frames against a long receiver hold fill the block until it stalls.
    set_dims(13'd8, 13'd1);
    hold_requests <= hold_requests + 1;
    no_gaps = 1'b1;
    repeat (48) send_byte(random_pixels(50));
    no_gaps = 1'b0;

    // Widest row, with the last pixel of the row set.
    set_dims(13'd8191, 13'd1);
    for (int col = 0; col < 512; col++) begin
      send_byte((col == 511) ? 8'h80 : random_pixels(2));
    end

    // A tall frame, three pixels wide, so the upper five bits of each byte are noise.
    set_dims(13'd3, 13'(TALL_ROWS));
    first_row = $urandom_range(0, TALL_ROWS - 1);
    for (int row = 0; row < TALL_ROWS; row++) begin
      send_byte((random_pixels(100) & 8'hF8) |
                ((row == first_row || row == TALL_ROWS - 1) ? 8'h04 : 8'h00));
    end

    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      w      = ($urandom_range(0, 19) == 0) ? 13'd0 : 13'($urandom_range(1, 40));
      h      = ($urandom_range(0, 19) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
      frames = $urandom_range(1, 5);
      if ($urandom_range(0, 39) == 0) begin
        w      = 13'($urandom_range(4096, 8191));
        h      = 13'd1;
        frames = 1;
      end
      set_dims(w, h);
      total = frames * ((bbox_checker::effective_dim(w) + 7) / 8) *
              bbox_checker::effective_dim(h);
      // Now and then stop partway, so the next size change lands mid-frame.
      if ($urandom_range(0, 4) == 0) begin
        total = $urandom_range(1, total);
      end
      case ($urandom_range(0, 3))
        0:       fill_pct = 0;
        1:       fill_pct = 5;
        2:       fill_pct = 30;
        default: fill_pct = 100;
      endcase
      repeat (total) send_byte(random_pixels(fill_pct));
      random_bytes += total;
    end

    idle_wait();
    $display("Checked %0d rectangles (%0d with pixels) over %0d mask bytes,",
             bbox.rects_checked, bbox.rects_found, bbox.bytes_seen);
    $display("widths from one pixel up to the 4096 clamp, with resizes inside frames.");
    if (bbox.errors == 0 && bbox.expected_rects.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
